>>> hdl/x86d_pkg.sv
// Shared types, opcode constants and helpers for the 16-bit x86 decode/execute block.
`timescale 1ns / 1ps

package x86d_pkg;

	// Operation codes
	localparam logic [2:0] OP_MOV  = 3'd0;
	localparam logic [2:0] OP_ADD  = 3'd1;
	localparam logic [2:0] OP_SUB  = 3'd2;
	localparam logic [2:0] OP_CMP  = 3'd3;
	localparam logic [2:0] OP_NONE = 3'd4;

	// Instruction forms
	localparam logic [2:0] FORM_REG_RM   = 3'd0;
	localparam logic [2:0] FORM_IMM_RM   = 3'd1;
	localparam logic [2:0] FORM_IMM_ACC  = 3'd2;
	localparam logic [2:0] FORM_ACC_ADDR = 3'd3;
	localparam logic [2:0] FORM_IMM_REG  = 3'd4;

	// Register file
	localparam int          RF_DEPTH = 8;
	localparam int          RF_AW    = $clog2(RF_DEPTH);
	localparam logic [3:0]  NO_REG   = 4'd8;
	localparam logic [1:0]  MOD_REG  = 2'd3;
	localparam logic [2:0]  RM_DIRECT = 3'd6;

	// Opcode groups, top six bits of the opcode
	localparam logic [5:0] G6_MOV_RM   = 6'b100010;
	localparam logic [5:0] G6_ADD_RM   = 6'b000000;
	localparam logic [5:0] G6_SUB_RM   = 6'b001010;
	localparam logic [5:0] G6_CMP_RM   = 6'b001110;
	localparam logic [5:0] G6_GRP_IMM  = 6'b100000;
	localparam logic [5:0] G6_MOV_ADDR = 6'b101000;
	// Opcode groups, top seven bits of the opcode
	localparam logic [6:0] G7_MOV_IMM_RM = 7'b1100011;
	localparam logic [6:0] G7_ADD_ACC    = 7'b0000010;
	localparam logic [6:0] G7_SUB_ACC    = 7'b0010110;
	localparam logic [6:0] G7_CMP_ACC    = 7'b0011110;
	// Top four bits of mov immediate to register
	localparam logic [3:0] G4_MOV_IMM_REG = 4'b1011;

	// reg field of the immediate group
	localparam logic [2:0] GRP_ADD = 3'd0;
	localparam logic [2:0] GRP_SUB = 3'd5;
	localparam logic [2:0] GRP_CMP = 3'd7;

	// Decoded instruction, carried from decode into the execute stage
	typedef struct packed {
		logic [2:0]            op;
		logic [2:0]            form;
		logic [2:0]            len;
		logic                  w;
		logic                  dir;
		logic [1:0]            mode;
		logic [2:0]            reg_f;
		logic [2:0]            rm;
		logic [15:0]           disp;
		logic [15:0]           imm;
		logic                  can_write;
		logic                  src_is_reg;
		logic [15:0]           src_imm;
		logic [RF_AW-1:0]      wr_idx;
		logic [RF_AW-1:0]      src_idx;
	} dec_t;

	// One result transaction
	typedef struct packed {
		logic [2:0]  op;
		logic [2:0]  form;
		logic [2:0]  len;
		logic        w;
		logic        dir;
		logic [1:0]  mode;
		logic [2:0]  reg_f;
		logic [2:0]  rm;
		logic [15:0] disp;
		logic [15:0] imm;
		logic [3:0]  dst;
		logic [15:0] nv;
	} res_t;

	// Sign-extend a byte to a word
	function automatic logic [15:0] sext8(input logic [7:0] v);
		return {{8{v[7]}}, v};
	endfunction

	// Number of displacement bytes that follow the addressing byte
	function automatic logic [1:0] disp_bytes(input logic [1:0] mode, input logic [2:0] rm);
		logic [1:0] n;
		case (mode)
			2'd0: n = (rm == RM_DIRECT) ? 2'd2 : 2'd0;
			2'd1: n = 2'd1;
			2'd2: n = 2'd2;
			default: n = 2'd0;
		endcase
		return n;
	endfunction

	// Word address of a register index at the given width
	function automatic logic [RF_AW-1:0] rf_addr(input logic [RF_AW-1:0] idx, input logic w);
		return w ? idx : {1'b0, idx[RF_AW-2:0]};
	endfunction

endpackage

>>> hdl/x86_16bit_decode_execute.sv
// Top level: 16-bit x86 mov/add/sub/cmp decoder with register-file execution.
`timescale 1ns / 1ps

// Usage
//   Instruction channel: byte0..byte5 with insn_valid / insn_stall. A transaction
//   completes on a rising edge with insn_valid high and insn_stall low.
//   Result channel: decoded fields, dest_register and new_value with res_valid /
//   res_stall, one result per instruction, in order.
//   cfg_write / cfg_data set exec_enable; write it only while the block is idle.
// Pipeline and throughput
//   Decode and register read load the execute-stage register; execute and
//   write-back load the output register.
//   One instruction per cycle sustained while res_stall is low; the register-file
//   read and the previous instruction's write-back share a cycle, with a bypass
//   on a matching address, so back-to-back dependent instructions run at full rate.
// Reset
//   arst_n clears exec_enable, the pipeline valids and the register-file valid
//   bits, so every register reads as zero until written.
// Stall
//   While res_stall holds a waiting result, the execute stage keeps its
//   instruction and insn_stall rises once that stage is also occupied.
module x86_16bit_decode_execute (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic               cfg_data,
	input  logic               insn_valid,
	output logic               insn_stall,
	input  logic [7:0]         byte0,
	input  logic [7:0]         byte1,
	input  logic [7:0]         byte2,
	input  logic [7:0]         byte3,
	input  logic [7:0]         byte4,
	input  logic [7:0]         byte5,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [2:0]         operation,
	output logic [2:0]         form,
	output logic [2:0]         length,
	output logic               word_op,
	output logic               direction,
	output logic [1:0]         mode_field,
	output logic [2:0]         reg_field,
	output logic [2:0]         rm_field,
	output logic signed [15:0] displacement,
	output logic signed [15:0] immediate,
	output logic [3:0]         dest_register,
	output logic [15:0]        new_value
);

	localparam int AW = x86d_pkg::RF_AW;

	logic              exec_enable_q;
	x86d_pkg::dec_t    dec;
	x86d_pkg::dec_t    dec_s1;
	logic              valid_s1;
	logic [15:0]       rd_a_s1;
	logic [15:0]       rd_b_s1;
	x86d_pkg::res_t    res;
	x86d_pkg::res_t    out_q;
	logic              out_valid_q;
	logic              s1_adv;
	logic              insn_acc;

	logic [15:0]       rf_mem [x86d_pkg::RF_DEPTH];
	logic [x86d_pkg::RF_DEPTH-1:0] rf_valid_q;
	logic              rf_we;
	logic [AW-1:0]     rf_waddr;
	logic [15:0]       rf_wdata;
	logic [AW-1:0]     ra_a;
	logic [AW-1:0]     ra_b;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exec_enable_q <= 1'b0;
		end else if (cfg_write) begin
			exec_enable_q <= cfg_data;
		end
	end

	// Handshake
	assign s1_adv     = valid_s1 && (!out_valid_q || !res_stall);
	assign insn_stall = valid_s1 && !s1_adv;
	assign insn_acc   = insn_valid && !insn_stall;

	// Decode
	always_comb begin
		logic [5:0] g6;
		logic [6:0] g7;
		logic [1:0] nd;
		logic [2:0] p;
		logic [7:0] lo;
		logic [7:0] hi;
		logic       is_mov;
		logic       s_bit;
		g6 = byte0[7:2];
		g7 = byte0[7:1];
		nd = 2'd0;
		p  = 3'd2;
		lo = 8'h00;
		hi = 8'h00;
		is_mov = 1'b0;
		s_bit  = 1'b0;
		dec = '0;
		dec.op  = x86d_pkg::OP_NONE;
		dec.len = 3'd1;

		if (g6 inside {x86d_pkg::G6_MOV_RM, x86d_pkg::G6_ADD_RM,
				x86d_pkg::G6_SUB_RM, x86d_pkg::G6_CMP_RM}) begin
			// register with register/memory
			if (g6 == x86d_pkg::G6_MOV_RM)      dec.op = x86d_pkg::OP_MOV;
			else if (g6 == x86d_pkg::G6_ADD_RM) dec.op = x86d_pkg::OP_ADD;
			else if (g6 == x86d_pkg::G6_SUB_RM) dec.op = x86d_pkg::OP_SUB;
			else                                dec.op = x86d_pkg::OP_CMP;
			dec.form  = x86d_pkg::FORM_REG_RM;
			dec.w     = byte0[0];
			dec.dir   = byte0[1];
			dec.mode  = byte1[7:6];
			dec.reg_f = byte1[5:3];
			dec.rm    = byte1[2:0];
			nd = x86d_pkg::disp_bytes(dec.mode, dec.rm);
			dec.len = 3'd2 + {1'b0, nd};
			if (nd == 2'd1)      dec.disp = x86d_pkg::sext8(byte2);
			else if (nd == 2'd2) dec.disp = {byte3, byte2};
			if (dec.mode == x86d_pkg::MOD_REG) begin
				dec.can_write  = 1'b1;
				dec.src_is_reg = 1'b1;
				dec.wr_idx  = dec.dir ? dec.reg_f : dec.rm;
				dec.src_idx = dec.dir ? dec.rm : dec.reg_f;
			end
		end else if (g6 == x86d_pkg::G6_GRP_IMM || g7 == x86d_pkg::G7_MOV_IMM_RM) begin
			// immediate to register/memory
			is_mov    = (g7 == x86d_pkg::G7_MOV_IMM_RM);
			s_bit     = is_mov ? 1'b0 : byte0[1];
			dec.form  = x86d_pkg::FORM_IMM_RM;
			dec.w     = byte0[0];
			dec.mode  = byte1[7:6];
			dec.reg_f = byte1[5:3];
			dec.rm    = byte1[2:0];
			if (is_mov)                             dec.op = x86d_pkg::OP_MOV;
			else if (dec.reg_f == x86d_pkg::GRP_ADD) dec.op = x86d_pkg::OP_ADD;
			else if (dec.reg_f == x86d_pkg::GRP_SUB) dec.op = x86d_pkg::OP_SUB;
			else if (dec.reg_f == x86d_pkg::GRP_CMP) dec.op = x86d_pkg::OP_CMP;
			else                                    dec.op = x86d_pkg::OP_NONE;
			nd = x86d_pkg::disp_bytes(dec.mode, dec.rm);
			if (nd == 2'd1)      dec.disp = x86d_pkg::sext8(byte2);
			else if (nd == 2'd2) dec.disp = {byte3, byte2};
			p = 3'd2 + {1'b0, nd};
			case (nd)
				2'd0: begin
					lo = byte2;
					hi = byte3;
				end
				2'd1: begin
					lo = byte3;
					hi = byte4;
				end
				default: begin
					lo = byte4;
					hi = byte5;
				end
			endcase
			if (dec.w && !s_bit) begin
				dec.imm = {hi, lo};
				dec.len = p + 3'd2;
			end else begin
				dec.imm = x86d_pkg::sext8(lo);
				dec.len = p + 3'd1;
			end
			dec.src_imm = dec.w ? dec.imm : {8'h00, dec.imm[7:0]};
			if (dec.mode == x86d_pkg::MOD_REG) begin
				dec.can_write = 1'b1;
				dec.wr_idx    = dec.rm;
			end
		end else if (g7 inside {x86d_pkg::G7_ADD_ACC, x86d_pkg::G7_SUB_ACC,
				x86d_pkg::G7_CMP_ACC}) begin
			// immediate with the accumulator
			if (g7 == x86d_pkg::G7_ADD_ACC)      dec.op = x86d_pkg::OP_ADD;
			else if (g7 == x86d_pkg::G7_SUB_ACC) dec.op = x86d_pkg::OP_SUB;
			else                                 dec.op = x86d_pkg::OP_CMP;
			dec.form = x86d_pkg::FORM_IMM_ACC;
			dec.w    = byte0[0];
			dec.dir  = 1'b1;
			if (dec.w) begin
				dec.imm = {byte2, byte1};
				dec.len = 3'd3;
			end else begin
				dec.imm = x86d_pkg::sext8(byte1);
				dec.len = 3'd2;
			end
			dec.src_imm   = dec.w ? dec.imm : {8'h00, dec.imm[7:0]};
			dec.can_write = 1'b1;
		end else if (g6 == x86d_pkg::G6_MOV_ADDR) begin
			// accumulator with a direct address, memory only
			dec.op   = x86d_pkg::OP_MOV;
			dec.form = x86d_pkg::FORM_ACC_ADDR;
			dec.w    = byte0[0];
			dec.dir  = ~byte0[1];
			dec.disp = {byte2, byte1};
			dec.len  = 3'd3;
		end else if (byte0[7:4] == x86d_pkg::G4_MOV_IMM_REG) begin
			// mov immediate to register
			dec.op    = x86d_pkg::OP_MOV;
			dec.form  = x86d_pkg::FORM_IMM_REG;
			dec.w     = byte0[3];
			dec.dir   = 1'b1;
			dec.reg_f = byte0[2:0];
			if (dec.w) begin
				dec.imm = {byte2, byte1};
				dec.len = 3'd3;
			end else begin
				dec.imm = x86d_pkg::sext8(byte1);
				dec.len = 3'd2;
			end
			dec.src_imm   = dec.w ? dec.imm : {8'h00, dec.imm[7:0]};
			dec.can_write = 1'b1;
			dec.wr_idx    = dec.reg_f;
		end
	end

	// Register file read addresses (destination and source)
	assign ra_a = x86d_pkg::rf_addr(dec.wr_idx, dec.w);
	assign ra_b = x86d_pkg::rf_addr(dec.src_idx, dec.w);

	// Execute stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (insn_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// Decoded instruction and registered reads, with write-back bypass
	always_ff @(posedge clk) begin
		if (insn_acc) begin
			dec_s1 <= dec;
			if (rf_we && rf_waddr == ra_a)
				rd_a_s1 <= rf_wdata;
			else
				rd_a_s1 <= rf_valid_q[ra_a] ? rf_mem[ra_a] : 16'h0000;
			if (rf_we && rf_waddr == ra_b)
				rd_b_s1 <= rf_wdata;
			else
				rd_b_s1 <= rf_valid_q[ra_b] ? rf_mem[ra_b] : 16'h0000;
		end
	end

	// Execute: operand select, ALU and merge into the full register
	always_comb begin
		logic [15:0] a_val;
		logic [15:0] s_val;
		logic [15:0] r;
		a_val = dec_s1.w ? rd_a_s1 :
			{8'h00, dec_s1.wr_idx[AW-1] ? rd_a_s1[15:8] : rd_a_s1[7:0]};
		if (dec_s1.src_is_reg)
			s_val = dec_s1.w ? rd_b_s1 :
				{8'h00, dec_s1.src_idx[AW-1] ? rd_b_s1[15:8] : rd_b_s1[7:0]};
		else
			s_val = dec_s1.src_imm;
		case (dec_s1.op)
			x86d_pkg::OP_MOV: r = s_val;
			x86d_pkg::OP_ADD: r = a_val + s_val;
			default:          r = a_val - s_val;
		endcase
		rf_waddr = x86d_pkg::rf_addr(dec_s1.wr_idx, dec_s1.w);
		if (dec_s1.w)
			rf_wdata = r;
		else if (dec_s1.wr_idx[AW-1])
			rf_wdata = {r[7:0], rd_a_s1[7:0]};
		else
			rf_wdata = {rd_a_s1[15:8], r[7:0]};
		rf_we = s1_adv && dec_s1.can_write && exec_enable_q &&
			(dec_s1.op == x86d_pkg::OP_MOV || dec_s1.op == x86d_pkg::OP_ADD ||
			 dec_s1.op == x86d_pkg::OP_SUB);

		res.op    = dec_s1.op;
		res.form  = dec_s1.form;
		res.len   = dec_s1.len;
		res.w     = dec_s1.w;
		res.dir   = dec_s1.dir;
		res.mode  = dec_s1.mode;
		res.reg_f = dec_s1.reg_f;
		res.rm    = dec_s1.rm;
		res.disp  = dec_s1.disp;
		res.imm   = dec_s1.imm;
		res.dst   = rf_we ? {1'b0, rf_waddr} : x86d_pkg::NO_REG;
		res.nv    = rf_we ? rf_wdata : 16'h0000;
	end

	// Register file storage
	always_ff @(posedge clk) begin
		if (rf_we)
			rf_mem[rf_waddr] <= rf_wdata;
	end

	// Per-entry valid bits, unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_valid_q <= '0;
		end else if (rf_we) begin
			rf_valid_q[rf_waddr] <= 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv)
			out_q <= res;
	end

	assign res_valid     = out_valid_q;
	assign operation     = out_q.op;
	assign form          = out_q.form;
	assign length        = out_q.len;
	assign word_op       = out_q.w;
	assign direction     = out_q.dir;
	assign mode_field    = out_q.mode;
	assign reg_field     = out_q.reg_f;
	assign rm_field      = out_q.rm;
	assign displacement  = out_q.disp;
	assign immediate     = out_q.imm;
	assign dest_register = out_q.dst;
	assign new_value     = out_q.nv;

	// Checks
	a_no_write_when_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		!exec_enable_q |-> !rf_we)
		else $error("register file written with execution disabled");

	a_written_entry_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rf_we |=> rf_valid_q[$past(rf_waddr)])
		else $error("written register entry not marked valid");

	a_byte_dest_low: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && dest_register != x86d_pkg::NO_REG && !word_op |->
		dest_register < 4'd4)
		else $error("byte write reported on an invalid full register");

	a_no_dest_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && dest_register == x86d_pkg::NO_REG |-> new_value == 16'h0000)
		else $error("new value reported without a register write");

endmodule

>>> dv/x86_16bit_decode_execute_test.sv
// Self-checking testbench for the 16-bit x86 decode/execute block.
`timescale 1ns / 1ps

module x86_16bit_decode_execute_test;

	typedef logic [5:0][7:0] insn_bytes_t;

	// One row of the directed table; want is used only when typed is set
	typedef struct {
		bit             en;
		bit             typed;
		x86d_pkg::res_t want;
		insn_bytes_t    bytes;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_write;
	logic               cfg_data;
	logic               insn_valid;
	logic               insn_stall;
	logic [7:0]         byte0, byte1, byte2, byte3, byte4, byte5;
	logic               res_valid;
	logic               res_stall;
	logic [2:0]         operation;
	logic [2:0]         form;
	logic [2:0]         length;
	logic               word_op;
	logic               direction;
	logic [1:0]         mode_field;
	logic [2:0]         reg_field;
	logic [2:0]         rm_field;
	logic signed [15:0] displacement;
	logic signed [15:0] immediate;
	logic [3:0]         dest_register;
	logic [15:0]        new_value;

	// Shadow copy of the register file and the enable
	logic [15:0] shadow_rf [8];
	bit          shadow_exec;

	x86d_pkg::res_t pending_results [$];
	stim_row_t      directed_rows [$];
	int             mismatch_count = 0;
	int             burst_left = 0;
	int             stall_mode = 0;
	int             stall_left = 0;

	x86_16bit_decode_execute dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_data      (cfg_data),
		.insn_valid    (insn_valid),
		.insn_stall    (insn_stall),
		.byte0         (byte0),
		.byte1         (byte1),
		.byte2         (byte2),
		.byte3         (byte3),
		.byte4         (byte4),
		.byte5         (byte5),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.operation     (operation),
		.form          (form),
		.length        (length),
		.word_op       (word_op),
		.direction     (direction),
		.mode_field    (mode_field),
		.reg_field     (reg_field),
		.rm_field      (rm_field),
		.displacement  (displacement),
		.immediate     (immediate),
		.dest_register (dest_register),
		.new_value     (new_value)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	// Register read at operand width; byte indices 4..7 are the high halves of 0..3
	function automatic logic [15:0] shadow_read(input logic [2:0] idx, input logic w);
		if (w)
			return shadow_rf[idx];
		if (!idx[2])
			return {8'h00, shadow_rf[idx][7:0]};
		return {8'h00, shadow_rf[{1'b0, idx[1:0]}][15:8]};
	endfunction

	// Register write at operand width; gives back the full register index
	function automatic logic [3:0] shadow_write(input logic [2:0] idx, input logic w,
			input logic [15:0] v);
		logic [2:0] word;
		word = w ? idx : {1'b0, idx[1:0]};
		if (w)
			shadow_rf[word] = v;
		else if (!idx[2])
			shadow_rf[word][7:0] = v[7:0];
		else
			shadow_rf[word][15:8] = v[7:0];
		return {1'b0, word};
	endfunction

	// Displacement bytes after the mod/reg/rm byte
	function automatic int addr_disp_count(input logic [1:0] mode, input logic [2:0] rm);
		case (mode)
			2'd0: return (rm == x86d_pkg::RM_DIRECT) ? 2 : 0;
			2'd1: return 1;
			2'd2: return 2;
			default: return 0;
		endcase
	endfunction

	// Decode one instruction and apply its register write to the shadow state
	function automatic x86d_pkg::res_t predict_decode(input insn_bytes_t b);
		x86d_pkg::res_t r;
		logic [5:0]     g6;
		logic [6:0]     g7;
		int             nd;
		int             p;
		bit             is_mov;
		logic           s;
		bit             wr_ok;
		logic [2:0]     wr_idx;
		logic [15:0]    src;
		logic [15:0]    acc;
		logic [15:0]    sum;

		r = '0;
		r.op = x86d_pkg::OP_NONE;
		r.form = x86d_pkg::FORM_REG_RM;
		r.len = 3'd1;
		r.dst = x86d_pkg::NO_REG;
		g6 = b[0][7:2];
		g7 = b[0][7:1];
		wr_ok = 0;
		wr_idx = 3'd0;
		src = 16'h0;
		nd = 0;

		if (g6 == x86d_pkg::G6_MOV_RM || g6 == x86d_pkg::G6_ADD_RM ||
				g6 == x86d_pkg::G6_SUB_RM || g6 == x86d_pkg::G6_CMP_RM) begin
			case (g6)
				x86d_pkg::G6_MOV_RM: r.op = x86d_pkg::OP_MOV;
				x86d_pkg::G6_ADD_RM: r.op = x86d_pkg::OP_ADD;
				x86d_pkg::G6_SUB_RM: r.op = x86d_pkg::OP_SUB;
				default:             r.op = x86d_pkg::OP_CMP;
			endcase
			r.w = b[0][0];
			r.dir = b[0][1];
			{r.mode, r.reg_f, r.rm} = b[1];
			nd = addr_disp_count(r.mode, r.rm);
			r.len = 3'(2 + nd);
			if (nd == 1)
				r.disp = {{8{b[2][7]}}, b[2]};
			else if (nd == 2)
				r.disp = {b[3], b[2]};
			if (r.mode == x86d_pkg::MOD_REG) begin
				wr_ok = 1;
				wr_idx = r.dir ? r.reg_f : r.rm;
				src = shadow_read(r.dir ? r.rm : r.reg_f, r.w);
			end
		end else if (g6 == x86d_pkg::G6_GRP_IMM || g7 == x86d_pkg::G7_MOV_IMM_RM) begin
			// C6/C7 is always mov and never sign-extends
			is_mov = (g7 == x86d_pkg::G7_MOV_IMM_RM);
			s = is_mov ? 1'b0 : b[0][1];
			r.form = x86d_pkg::FORM_IMM_RM;
			r.w = b[0][0];
			r.dir = 1'b0;
			{r.mode, r.reg_f, r.rm} = b[1];
			if (is_mov)
				r.op = x86d_pkg::OP_MOV;
			else if (r.reg_f == x86d_pkg::GRP_ADD)
				r.op = x86d_pkg::OP_ADD;
			else if (r.reg_f == x86d_pkg::GRP_SUB)
				r.op = x86d_pkg::OP_SUB;
			else if (r.reg_f == x86d_pkg::GRP_CMP)
				r.op = x86d_pkg::OP_CMP;
			else
				r.op = x86d_pkg::OP_NONE;
			nd = addr_disp_count(r.mode, r.rm);
			if (nd == 1)
				r.disp = {{8{b[2][7]}}, b[2]};
			else if (nd == 2)
				r.disp = {b[3], b[2]};
			p = 2 + nd;
			if (r.w && !s) begin
				r.imm = {b[p + 1], b[p]};
				r.len = 3'(p + 2);
			end else begin
				r.imm = {{8{b[p][7]}}, b[p]};
				r.len = 3'(p + 1);
			end
			if (r.mode == x86d_pkg::MOD_REG) begin
				wr_ok = 1;
				wr_idx = r.rm;
				src = r.w ? r.imm : {8'h00, r.imm[7:0]};
			end
		end else if (g7 == x86d_pkg::G7_ADD_ACC || g7 == x86d_pkg::G7_SUB_ACC ||
				g7 == x86d_pkg::G7_CMP_ACC) begin
			if (g7 == x86d_pkg::G7_ADD_ACC)
				r.op = x86d_pkg::OP_ADD;
			else if (g7 == x86d_pkg::G7_SUB_ACC)
				r.op = x86d_pkg::OP_SUB;
			else
				r.op = x86d_pkg::OP_CMP;
			r.form = x86d_pkg::FORM_IMM_ACC;
			r.w = b[0][0];
			r.dir = 1'b1;
			if (r.w) begin
				r.imm = {b[2], b[1]};
				r.len = 3'd3;
			end else begin
				r.imm = {{8{b[1][7]}}, b[1]};
				r.len = 3'd2;
			end
			wr_ok = 1;
			wr_idx = 3'd0;
			src = r.w ? r.imm : {8'h00, r.imm[7:0]};
		end else if (g6 == x86d_pkg::G6_MOV_ADDR) begin
			// Accumulator against a direct address: memory only
			r.op = x86d_pkg::OP_MOV;
			r.form = x86d_pkg::FORM_ACC_ADDR;
			r.w = b[0][0];
			r.dir = ~b[0][1];
			r.disp = {b[2], b[1]};
			r.len = 3'd3;
		end else if (b[0][7:4] == x86d_pkg::G4_MOV_IMM_REG) begin
			r.op = x86d_pkg::OP_MOV;
			r.form = x86d_pkg::FORM_IMM_REG;
			r.w = b[0][3];
			r.dir = 1'b1;
			r.reg_f = b[0][2:0];
			if (r.w) begin
				r.imm = {b[2], b[1]};
				r.len = 3'd3;
			end else begin
				r.imm = {{8{b[1][7]}}, b[1]};
				r.len = 3'd2;
			end
			wr_ok = 1;
			wr_idx = r.reg_f;
			src = r.w ? r.imm : {8'h00, r.imm[7:0]};
		end

		// Write-back: register destinations only, never for cmp or unknown ops
		if (wr_ok && shadow_exec && r.op <= x86d_pkg::OP_SUB) begin
			acc = shadow_read(wr_idx, r.w);
			case (r.op)
				x86d_pkg::OP_MOV: sum = src;
				x86d_pkg::OP_ADD: sum = acc + src;
				default:          sum = acc - src;
			endcase
			if (!r.w)
				sum[15:8] = 8'h00;
			r.dst = shadow_write(wr_idx, r.w, sum);
			r.nv = shadow_rf[r.dst[2:0]];
		end
		return r;
	endfunction

	// Random instruction, mostly well-formed with a share of noise
	function automatic insn_bytes_t gen_insn();
		insn_bytes_t b;
		int          kind;
		for (int i = 0; i < 6; i++)
			b[i] = 8'($urandom);
		if ($urandom_range(0, 1) == 1)
			b[1][7:6] = x86d_pkg::MOD_REG;
		kind = $urandom_range(0, 9);
		case (kind)
			0, 1: begin
				case ($urandom_range(0, 3))
					0: b[0][7:2] = x86d_pkg::G6_MOV_RM;
					1: b[0][7:2] = x86d_pkg::G6_ADD_RM;
					2: b[0][7:2] = x86d_pkg::G6_SUB_RM;
					default: b[0][7:2] = x86d_pkg::G6_CMP_RM;
				endcase
			end
			2: begin
				b[0][7:2] = x86d_pkg::G6_GRP_IMM;
				case ($urandom_range(0, 3))
					0: b[1][5:3] = x86d_pkg::GRP_ADD;
					1: b[1][5:3] = x86d_pkg::GRP_SUB;
					2: b[1][5:3] = x86d_pkg::GRP_CMP;
					default: ;
				endcase
			end
			3: b[0][7:1] = x86d_pkg::G7_MOV_IMM_RM;
			4: begin
				case ($urandom_range(0, 2))
					0: b[0][7:1] = x86d_pkg::G7_ADD_ACC;
					1: b[0][7:1] = x86d_pkg::G7_SUB_ACC;
					default: b[0][7:1] = x86d_pkg::G7_CMP_ACC;
				endcase
			end
			5: b[0][7:2] = x86d_pkg::G6_MOV_ADDR;
			6, 7: b[0][7:4] = x86d_pkg::G4_MOV_IMM_REG;
			default: ;
		endcase
		return b;
	endfunction

	function automatic void add_row(input bit en, input bit typed,
			input x86d_pkg::res_t want,
			input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
			input logic [7:0] b3, input logic [7:0] b4, input logic [7:0] b5);
		stim_row_t row;
		row.en = en;
		row.typed = typed;
		row.want = want;
		row.bytes = {b5, b4, b3, b2, b1, b0};
		directed_rows.push_back(row);
	endfunction

	// Drive one instruction transaction and wait for it to be taken
	task automatic send_insn(input insn_bytes_t b, input bit typed,
			input x86d_pkg::res_t want);
		x86d_pkg::res_t pred;
		insn_valid <= 1'b1;
		byte0 <= b[0];
		byte1 <= b[1];
		byte2 <= b[2];
		byte3 <= b[3];
		byte4 <= b[4];
		byte5 <= b[5];
		do @(posedge clk); while (insn_stall);
		pred = predict_decode(b);
		pending_results.push_back(typed ? want : pred);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			insn_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
				: $urandom_range(0, 12);
		end
	endtask

	// Enable write, only once the pipeline has drained
	task automatic set_exec(input bit en);
		insn_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_data <= en;
		@(posedge clk);
		cfg_write <= 1'b0;
		shadow_exec = en;
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			mismatch_count++;
		end
	endtask

	// Receiver back-pressure: off, light, heavy or alternating, chosen at random
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(16, 120);
		end
		stall_left--;
		case (stall_mode)
			0: res_stall <= 1'b0;
			1: res_stall <= ($urandom_range(0, 9) < 3);
			2: res_stall <= ($urandom_range(0, 9) < 7);
			default: res_stall <= ~res_stall;
		endcase
	end

	// Result checker: each accepted transaction against the oldest expectation
	always @(posedge clk) begin
		x86d_pkg::res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with no instruction outstanding");
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("operation", 16'(want.op), 16'(operation));
				check_field("form", 16'(want.form), 16'(form));
				check_field("length", 16'(want.len), 16'(length));
				check_field("word_op", 16'(want.w), 16'(word_op));
				check_field("direction", 16'(want.dir), 16'(direction));
				check_field("mode_field", 16'(want.mode), 16'(mode_field));
				check_field("reg_field", 16'(want.reg_f), 16'(reg_field));
				check_field("rm_field", 16'(want.rm), 16'(rm_field));
				check_field("displacement", want.disp, displacement);
				check_field("immediate", want.imm, immediate);
				check_field("dest_register", 16'(want.dst), 16'(dest_register));
				check_field("new_value", want.nv, new_value);
			end
		end
	end

	// Stimulus
	initial begin
		bit phase_exec [3];
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_data <= 1'b0;
		insn_valid <= 1'b0;
		res_stall <= 1'b0;
		byte0 <= 8'h00;
		byte1 <= 8'h00;
		byte2 <= 8'h00;
		byte3 <= 8'h00;
		byte4 <= 8'h00;
		byte5 <= 8'h00;
		for (int i = 0; i < 8; i++)
			shadow_rf[i] = 16'h0000;
		shadow_exec = 0;
		phase_exec = '{1'b1, 1'b0, 1'b1};

		// Decode only: unknown opcode, each addressing mode, rejected group op
		add_row(0, 1, '{x86d_pkg::OP_NONE, x86d_pkg::FORM_REG_RM, 3'd1, 1'b0, 1'b0,
			2'd0, 3'd0, 3'd0, 16'h0, 16'h0, x86d_pkg::NO_REG, 16'h0},
			8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		add_row(0, 1, '{x86d_pkg::OP_ADD, x86d_pkg::FORM_REG_RM, 3'd2, 1'b0, 1'b0,
			2'd0, 3'd0, 3'd0, 16'h0, 16'h0, x86d_pkg::NO_REG, 16'h0},
			8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		add_row(0, 0, '0, 8'h89, 8'h06, 8'h34, 8'h12, 8'h00, 8'h00);
		add_row(0, 0, '0, 8'h8B, 8'h47, 8'h80, 8'h00, 8'h00, 8'h00);
		add_row(0, 0, '0, 8'h03, 8'h87, 8'hFF, 8'h7F, 8'h00, 8'h00);
		add_row(0, 0, '0, 8'h2B, 8'hC1, 8'h00, 8'h00, 8'h00, 8'h00);
		add_row(0, 1, '{x86d_pkg::OP_NONE, x86d_pkg::FORM_IMM_RM, 3'd3, 1'b0, 1'b0,
			2'd3, 3'd1, 3'd0, 16'h0, 16'h0, x86d_pkg::NO_REG, 16'h0},
			8'h80, 8'hC8, 8'h00, 8'h00, 8'h00, 8'h00);
		add_row(0, 0, '0, 8'hA1, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00);
		add_row(0, 0, '0, 8'hA3, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00);
		// Execution on: extremes, wrap, byte halves, cmp, C6/C7, longest forms
		add_row(1, 1, '{x86d_pkg::OP_MOV, x86d_pkg::FORM_IMM_REG, 3'd3, 1'b1, 1'b1,
			2'd0, 3'd0, 3'd0, 16'h0, 16'hFFFF, 4'd0, 16'hFFFF},
			8'hB8, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00);
		add_row(1, 1, '{x86d_pkg::OP_ADD, x86d_pkg::FORM_IMM_ACC, 3'd3, 1'b1, 1'b1,
			2'd0, 3'd0, 3'd0, 16'h0, 16'h0001, 4'd0, 16'h0000},
			8'h05, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00);
		add_row(1, 0, '0, 8'hB4, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00);
		add_row(1, 0, '0, 8'hB3, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00);
		add_row(1, 0, '0, 8'h00, 8'hE3, 8'h00, 8'h00, 8'h00, 8'h00);
		add_row(1, 0, '0, 8'h28, 8'hDC, 8'h00, 8'h00, 8'h00, 8'h00);
		add_row(1, 0, '0, 8'h3B, 8'hC3, 8'h00, 8'h00, 8'h00, 8'h00);
		add_row(1, 0, '0, 8'h8B, 8'hCB, 8'h00, 8'h00, 8'h00, 8'h00);
		add_row(1, 0, '0, 8'h81, 8'hC1, 8'hFF, 8'hFF, 8'h00, 8'h00);
		add_row(1, 0, '0, 8'h83, 8'hE9, 8'h80, 8'h00, 8'h00, 8'h00);
		add_row(1, 0, '0, 8'h83, 8'hF9, 8'h01, 8'h00, 8'h00, 8'h00);
		add_row(1, 0, '0, 8'hC6, 8'hC2, 8'h55, 8'h00, 8'h00, 8'h00);
		add_row(1, 0, '0, 8'hC7, 8'hF2, 8'h34, 8'h12, 8'h00, 8'h00);
		add_row(1, 0, '0, 8'hC7, 8'h46, 8'hFE, 8'hCD, 8'hAB, 8'h00);
		add_row(1, 0, '0, 8'h81, 8'h86, 8'h00, 8'h01, 8'hFF, 8'h7F);
		add_row(1, 0, '0, 8'h2C, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00);
		add_row(1, 0, '0, 8'h2D, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00);
		add_row(1, 0, '0, 8'hBF, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00);
		add_row(1, 0, '0, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_exec(0);

		// Directed table
		foreach (directed_rows[i]) begin
			if (directed_rows[i].en != shadow_exec)
				set_exec(directed_rows[i].en);
			send_insn(directed_rows[i].bytes, directed_rows[i].typed,
				directed_rows[i].want);
		end

		// Random phases with the enable changed between them
		foreach (phase_exec[k]) begin
			set_exec(phase_exec[k]);
			repeat (250) send_insn(gen_insn(), 1'b0, '0);
		end

		insn_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> x86_16bit_decode_execute.f
hdl/x86d_pkg.sv
hdl/x86_16bit_decode_execute.sv
dv/x86_16bit_decode_execute_test.sv
